/* rtl/core/mstw_pkg.sv */
// Shared package for the minimum spanning tree weight unit.
// Holds operation, status and register codes, saturation limits and the controller states.
// No dependencies.
package mstw_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_RUN   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_VERT = 2'd2
    } status_t;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_START_VERTEX = 2'd1;

    localparam logic [63:0] TOTAL_MAX = 64'd4194303;
    localparam logic [63:0] REACH_MAX = 64'd127;

    localparam logic [5:0] VERTEX_COUNT_RST = 6'd63;
    localparam logic [5:0] START_VERTEX_RST = 6'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_SCAN,
        S_PICK,
        S_EDGE_RD,
        S_EDGE_CHK,
        S_KEY_UPD
    } state_t;

endpackage

/* rtl/core/mstw_ram.sv */
// Synchronous single-write, single-read memory with registered read data.
// Used for the edge store and the per-vertex key table; no dependencies.
module mstw_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 18
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/min_spanning_tree_weight_unit.sv */
// Top level of the minimum spanning tree weight unit.
// Depends on mstw_pkg and mstw_ram (edge store and per-vertex key table).
//
// Usage: present an item on operation/end_a/end_b/edge_weight with start high;
// it transfers at a rising edge where start is high and busy is low. Every item
// gives one result on status/total_weight/vertices_reached, marked by
// result_valid for one cycle, the cycle after the item completes.
// Add edge, clear, unused codes and a run with a bad start vertex finish in idle;
// busy stays low, so such items can transfer every cycle.
// A run holds busy while it works: it clears the key table, seeds the start vertex,
// then for each vertex joined scans the key table, picks that vertex and reads
// each stored edge, and ends with a final scan and pick. The key table has a
// single read port, shared by the scan and the edge checks.
// The configuration channel (cfg_valid, cfg_index, cfg_data) is always ready;
// write it only while no item is in progress.
// Reset empties the edge store, sets vertex_count to 63 and start_vertex to 0.
// The receiver cannot stall; each result must be taken in its strobe cycle.
module min_spanning_tree_weight_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [5:0]  end_a,
    input  logic [5:0]  end_b,
    input  logic [15:0] edge_weight,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [21:0] total_weight,
    output logic [6:0]  vertices_reached,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int VB  = $clog2(MAX_VERTICES);
    localparam int CW  = VB + 1;
    localparam int IW  = (VB > 6) ? VB : 6;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int WB  = WEIGHT_BITS;
    localparam int EW  = 2 * VB + WB;
    localparam int KW  = WB + 2;
    localparam int SW  = WB + VB + 1;

    mstw_pkg::state_t state_reg, state_next;

    logic [5:0]     vertex_count_reg;
    logic [5:0]     start_vertex_reg;
    logic [ETW-1:0] edge_total_reg, edge_total_next;
    logic [CW-1:0]  scan_idx_reg, scan_idx_next;
    logic           pend_reg, pend_next;
    logic [VB-1:0]  pend_addr_reg, pend_addr_next;
    logic           found_reg, found_next;
    logic [VB-1:0]  pick_reg, pick_next;
    logic [WB-1:0]  best_reg, best_next;
    logic [SW-1:0]  sum_reg, sum_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [ETW-1:0] edge_idx_reg, edge_idx_next;
    logic [VB-1:0]  other_reg, other_next;
    logic [WB-1:0]  cand_w_reg, cand_w_next;
    logic           res_valid_reg, res_valid_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [21:0]    res_total_reg, res_total_next;
    logic [6:0]     res_reach_reg, res_reach_next;

    logic           accept;
    logic [IW-1:0]  top_ext;
    logic [VB-1:0]  top_v;
    logic [IW-1:0]  start_ext;
    logic           a_bad, start_bad, store_full;
    logic [47:0]    w_wide;
    logic [WB-1:0]  w_in;

    logic           ewr_en, erd_en;
    logic [EAW-1:0] erd_addr;
    logic [EW-1:0]  erd_data;
    logic           kwr_en, krd_en;
    logic [VB-1:0]  kwr_addr, krd_addr;
    logic [KW-1:0]  kwr_data, krd_data;

    logic [VB-1:0]  ea, eb;
    logic [WB-1:0]  ew;
    logic           edge_in_range, edge_hits, edge_last;
    logic [VB-1:0]  edge_other;
    logic           k_visited, k_has;
    logic [WB-1:0]  k_key;
    logic           scan_issue, scan_done;
    logic [21:0]    sat_total;
    logic [6:0]     sat_reach;

    assign accept     = start && !busy;
    assign busy       = (state_reg != mstw_pkg::S_IDLE);
    assign cfg_ready  = 1'b1;

    assign top_ext    = (IW'(vertex_count_reg) > IW'(MAX_VERTICES - 1))
                        ? IW'(MAX_VERTICES - 1) : IW'(vertex_count_reg);
    assign top_v      = top_ext[VB-1:0];
    assign start_ext  = IW'(start_vertex_reg);
    assign a_bad      = (IW'(end_a) > top_ext) || (IW'(end_b) > top_ext);
    assign start_bad  = start_ext > top_ext;
    assign store_full = edge_total_reg >= ETW'(MAX_EDGES);
    assign w_wide     = {32'd0, edge_weight};
    assign w_in       = w_wide[WB-1:0];

    assign ea = erd_data[EW-1:EW-VB];
    assign eb = erd_data[EW-VB-1:WB];
    assign ew = erd_data[WB-1:0];
    assign edge_in_range = (ea <= top_v) && (eb <= top_v);
    assign edge_hits     = edge_in_range && ((ea == pick_reg) || (eb == pick_reg));
    assign edge_other    = (ea == pick_reg) ? eb : ea;
    assign edge_last     = ((edge_idx_reg + ETW'(1)) == edge_total_reg);

    assign k_visited = krd_data[KW-1];
    assign k_has     = krd_data[KW-2];
    assign k_key     = krd_data[WB-1:0];

    assign scan_issue = scan_idx_reg <= CW'(top_v);
    assign scan_done  = !scan_issue && !pend_reg;

    assign sat_total = (64'(sum_reg) > mstw_pkg::TOTAL_MAX) ? 22'h3FFFFF : 22'(sum_reg);
    assign sat_reach = (64'(cnt_reg) > mstw_pkg::REACH_MAX) ? 7'h7F : 7'(cnt_reg);

    mstw_ram #(
        .DEPTH (MAX_EDGES),
        .AW    (EAW),
        .DW    (EW)
    ) u_edge_mem (
        .clk     (clk),
        .wr_en   (ewr_en),
        .wr_addr (edge_total_reg[EAW-1:0]),
        .wr_data ({VB'(end_a), VB'(end_b), w_in}),
        .rd_en   (erd_en),
        .rd_addr (erd_addr),
        .rd_data (erd_data)
    );

    mstw_ram #(
        .DEPTH (MAX_VERTICES),
        .AW    (VB),
        .DW    (KW)
    ) u_key_mem (
        .clk     (clk),
        .wr_en   (kwr_en),
        .wr_addr (kwr_addr),
        .wr_data (kwr_data),
        .rd_en   (krd_en),
        .rd_addr (krd_addr),
        .rd_data (krd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mstw_pkg::S_IDLE:
            begin
                if (accept && (operation == mstw_pkg::OP_RUN) && !start_bad)
                begin
                    state_next = mstw_pkg::S_CLEAR;
                end
            end
            mstw_pkg::S_CLEAR:
            begin
                if (scan_idx_reg == CW'(MAX_VERTICES - 1))
                begin
                    state_next = mstw_pkg::S_SEED;
                end
            end
            mstw_pkg::S_SEED:
            begin
                state_next = mstw_pkg::S_SCAN;
            end
            mstw_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = mstw_pkg::S_PICK;
                end
            end
            mstw_pkg::S_PICK:
            begin
                priority if (!found_reg)
                begin
                    state_next = mstw_pkg::S_IDLE;
                end
                else if (edge_total_reg == '0)
                begin
                    state_next = mstw_pkg::S_SCAN;
                end
                else
                begin
                    state_next = mstw_pkg::S_EDGE_RD;
                end
            end
            mstw_pkg::S_EDGE_RD:
            begin
                state_next = mstw_pkg::S_EDGE_CHK;
            end
            mstw_pkg::S_EDGE_CHK:
            begin
                priority if (edge_hits)
                begin
                    state_next = mstw_pkg::S_KEY_UPD;
                end
                else if (edge_last)
                begin
                    state_next = mstw_pkg::S_SCAN;
                end
                else
                begin
                    state_next = mstw_pkg::S_EDGE_RD;
                end
            end
            mstw_pkg::S_KEY_UPD:
            begin
                state_next = edge_last ? mstw_pkg::S_SCAN : mstw_pkg::S_EDGE_RD;
            end
            default:
            begin
                state_next = mstw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        edge_total_next = edge_total_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        edge_idx_next   = edge_idx_reg;
        other_next      = other_reg;
        cand_w_next     = cand_w_reg;
        res_valid_next  = 1'b0;
        res_status_next = res_status_reg;
        res_total_next  = res_total_reg;
        res_reach_next  = res_reach_reg;
        ewr_en          = 1'b0;
        erd_en          = 1'b0;
        erd_addr        = edge_idx_reg[EAW-1:0];
        kwr_en          = 1'b0;
        kwr_addr        = scan_idx_reg[VB-1:0];
        kwr_data        = '0;
        krd_en          = 1'b0;
        krd_addr        = scan_idx_reg[VB-1:0];
        unique case (state_reg)
            mstw_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = mstw_pkg::ST_OK;
                    res_total_next  = '0;
                    res_reach_next  = '0;
                    scan_idx_next   = '0;
                    unique case (operation)
                        mstw_pkg::OP_ADD:
                        begin
                            res_valid_next = 1'b1;
                            priority if (a_bad)
                            begin
                                res_status_next = mstw_pkg::ST_BAD_VERT;
                            end
                            else if (store_full)
                            begin
                                res_status_next = mstw_pkg::ST_FULL;
                            end
                            else
                            begin
                                ewr_en          = 1'b1;
                                edge_total_next = edge_total_reg + ETW'(1);
                            end
                        end
                        mstw_pkg::OP_RUN:
                        begin
                            if (start_bad)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = mstw_pkg::ST_BAD_VERT;
                            end
                        end
                        mstw_pkg::OP_CLEAR:
                        begin
                            res_valid_next  = 1'b1;
                            edge_total_next = '0;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            mstw_pkg::S_CLEAR:
            begin
                kwr_en        = 1'b1;
                kwr_addr      = scan_idx_reg[VB-1:0];
                kwr_data      = '0;
                scan_idx_next = scan_idx_reg + CW'(1);
            end
            mstw_pkg::S_SEED:
            begin
                kwr_en        = 1'b1;
                kwr_addr      = start_ext[VB-1:0];
                kwr_data      = {1'b0, 1'b1, {WB{1'b0}}};
                scan_idx_next = '0;
                pend_next     = 1'b0;
                found_next    = 1'b0;
                sum_next      = '0;
                cnt_next      = '0;
            end
            mstw_pkg::S_SCAN:
            begin
                if (pend_reg && !k_visited && k_has && (!found_reg || (k_key < best_reg)))
                begin
                    found_next = 1'b1;
                    pick_next  = pend_addr_reg;
                    best_next  = k_key;
                end
                if (scan_issue)
                begin
                    krd_en         = 1'b1;
                    krd_addr       = scan_idx_reg[VB-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = scan_idx_reg[VB-1:0];
                    scan_idx_next  = scan_idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            mstw_pkg::S_PICK:
            begin
                if (!found_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = mstw_pkg::ST_OK;
                    res_total_next  = sat_total;
                    res_reach_next  = sat_reach;
                end
                else
                begin
                    kwr_en        = 1'b1;
                    kwr_addr      = pick_reg;
                    kwr_data      = {1'b1, 1'b1, best_reg};
                    sum_next      = sum_reg + SW'(best_reg);
                    cnt_next      = cnt_reg + CW'(1);
                    edge_idx_next = '0;
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    pend_next     = 1'b0;
                end
            end
            mstw_pkg::S_EDGE_RD:
            begin
                erd_en   = 1'b1;
                erd_addr = edge_idx_reg[EAW-1:0];
            end
            mstw_pkg::S_EDGE_CHK:
            begin
                if (edge_hits)
                begin
                    krd_en      = 1'b1;
                    krd_addr    = edge_other;
                    other_next  = edge_other;
                    cand_w_next = ew;
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + ETW'(1);
                end
            end
            mstw_pkg::S_KEY_UPD:
            begin
                if (!k_visited && (!k_has || (cand_w_reg < k_key)))
                begin
                    kwr_en   = 1'b1;
                    kwr_addr = other_reg;
                    kwr_data = {1'b0, 1'b1, cand_w_reg};
                end
                edge_idx_next = edge_idx_reg + ETW'(1);
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mstw_pkg::S_IDLE;
            edge_total_reg   <= '0;
            vertex_count_reg <= mstw_pkg::VERTEX_COUNT_RST;
            start_vertex_reg <= mstw_pkg::START_VERTEX_RST;
            res_valid_reg    <= 1'b0;
            pend_reg         <= 1'b0;
            found_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            res_valid_reg  <= res_valid_next;
            pend_reg       <= pend_next;
            found_reg      <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mstw_pkg::CFG_VERTEX_COUNT)
                begin
                    vertex_count_reg <= cfg_data;
                end
                else if (cfg_index == mstw_pkg::CFG_START_VERTEX)
                begin
                    start_vertex_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        pend_addr_reg  <= pend_addr_next;
        pick_reg       <= pick_next;
        best_reg       <= best_next;
        sum_reg        <= sum_next;
        cnt_reg        <= cnt_next;
        edge_idx_reg   <= edge_idx_next;
        other_reg      <= other_next;
        cand_w_reg     <= cand_w_next;
        res_status_reg <= res_status_next;
        res_total_reg  <= res_total_next;
        res_reach_reg  <= res_reach_next;
    end

    assign result_valid     = res_valid_reg;
    assign status           = res_status_reg;
    assign total_weight     = res_total_reg;
    assign vertices_reached = res_reach_reg;

endmodule
